// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file u8dec_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/u8dec_pkg.sv =====
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam int CODE_W         = 31;
    localparam int TOTAL_W        = 20;
    localparam int TDATA_IN_W     = 8;
    localparam int TDATA_OUT_W    = 56;  // code + total, padded to bytes
    localparam int COUNT_BITS_DEF = 20;

    localparam logic [15:0] SUR_HI  = 16'hD800;
    localparam logic [15:0] SUR_LO  = 16'hDC00;
    localparam logic [19:0] SUR_OFS = 20'h10000;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               term;
        logic [CODE_W-1:0]  code;
    } t_result;

endpackage

// ===== rtl/core/utf8_stream_to_utf16_or_utf32.sv =====
`timescale 1ns / 1ps
// Accepted bytes are registered, then their words enter the output queue.
// Throughput: one byte per cycle while each byte yields one word or none and
//   the output does not stall; a byte that yields 2 or 3 words (surrogate
//   pair, terminator) may hold the input until the 3-entry queue has room.
// Reset: synchronous active-low i_rst_n clears decode state, the unit count
//   and the queue, and sets wide_output to 1 (UTF-32).
module utf8_stream_to_utf16_or_utf32 #(
    parameter int COUNT_BITS = u8dec_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: wide_output
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data,
    // byte input
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [u8dec_pkg::TDATA_IN_W-1:0]   i_s_tdata,  // [7:0] data_byte
    input  logic                               i_s_tlast,  // end_of_text
    // word output
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [u8dec_pkg::TDATA_OUT_W-1:0]  o_m_tdata,  // [30:0] code_unit,
                                                           // [50:31] total_units,
                                                           // [55:51] zero
    output logic                               o_m_tlast   // is_terminator
);

    localparam int CW = u8dec_pkg::CODE_W;
    localparam int TW = u8dec_pkg::TOTAL_W;

    // ---------------- registers ----------------
    logic                  r_wide;
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic [CW-1:0]         r_acc,   n_acc;
    logic [2:0]            r_rem,   n_rem;
    logic [2:0]            r_len,   n_len;
    logic [COUNT_BITS-1:0] r_cnt,   n_cnt;
    logic                  r_ended, n_ended;
    u8dec_pkg::t_result    r_q [3];
    u8dec_pkg::t_result    n_q [3];
    logic [1:0]            r_q_cnt, n_q_cnt;

    // ---------------- decode of the held byte ----------------
    logic [2:0]            lead_len;
    logic [6:0]            lead_bits;
    logic                  lead_skip;
    logic [CW-1:0]         v_acc;
    logic                  code_go, term_go, pair;
    logic [1:0]            nu;
    logic [19:0]           sur_d;
    logic [CW-1:0]         u0, u1;
    logic [COUNT_BITS:0]   cnt_sum;
    logic [COUNT_BITS-1:0] cnt_mid;
    logic [31:0]           cnt_ext;
    u8dec_pkg::t_result    res [3];
    logic [1:0]            n_res;
    logic                  pop, move;
    logic [1:0]            q_base;
    logic [2:0]            q_need;

    assign o_cfg_ready = 1'b1;

    // lead byte classes; stray continuation and 0xFE/0xFF are skipped
    always_comb begin
        lead_skip = (r_in_byte[7:6] == 2'b10) || (r_in_byte[7:1] == 7'b1111111);
        if (!r_in_byte[7]) begin
            lead_len  = 3'd1;
            lead_bits = r_in_byte[6:0];
        end else if (r_in_byte[7:5] == 3'b110) begin
            lead_len  = 3'd2;
            lead_bits = {2'b0, r_in_byte[4:0]};
        end else if (r_in_byte[7:4] == 4'b1110) begin
            lead_len  = 3'd3;
            lead_bits = {3'b0, r_in_byte[3:0]};
        end else if (r_in_byte[7:3] == 5'b11110) begin
            lead_len  = 3'd4;
            lead_bits = {4'b0, r_in_byte[2:0]};
        end else if (r_in_byte[7:2] == 6'b111110) begin
            lead_len  = 3'd5;
            lead_bits = {5'b0, r_in_byte[1:0]};
        end else begin
            lead_len  = 3'd6;
            lead_bits = {6'b0, r_in_byte[0]};
        end
    end

    // sequence state update
    always_comb begin
        v_acc   = r_acc;
        n_rem   = r_rem;
        n_len   = r_len;
        n_ended = r_ended;
        code_go = 1'b0;
        term_go = 1'b0;
        if (!r_ended) begin
            if (r_rem != 3'd0) begin
                // continuation position: no check, low six bits shifted in
                v_acc = {r_acc[CW-7:0], r_in_byte[5:0]};
                n_rem = r_rem - 3'd1;
                code_go = (r_rem == 3'd1);
            end else if (r_in_byte == 8'd0) begin
                term_go = 1'b1;
            end else if (!lead_skip) begin
                n_len   = lead_len;
                v_acc   = CW'(lead_bits);
                n_rem   = lead_len - 3'd1;
                code_go = (lead_len == 3'd1);
            end
            if (r_in_last) begin
                term_go = 1'b1;  // a cut-short sequence is dropped here
            end
        end
        n_acc = v_acc;
        if (term_go) begin
            n_ended = 1'b1;
            n_rem   = 3'd0;
            n_len   = 3'd0;
            n_acc   = '0;
        end
    end

    // code emission: UTF-32 whole, UTF-16 one unit or a surrogate pair
    always_comb begin
        // only a completing continuation can close a 4- to 6-byte sequence
        pair  = !r_wide && (r_rem != 3'd0) && (r_len > 3'd3);
        // only the low 20 bits of the wrapped subtraction reach the output
        sur_d = v_acc[19:0] - u8dec_pkg::SUR_OFS;
        nu    = code_go ? (pair ? 2'd2 : 2'd1) : 2'd0;
        if (r_wide) begin
            u0 = v_acc;
        end else if (pair) begin
            u0 = CW'(u8dec_pkg::SUR_HI | {6'b0, sur_d[19:10]});
        end else begin
            u0 = CW'(v_acc[15:0]);
        end
        u1 = CW'(u8dec_pkg::SUR_LO | {6'b0, sur_d[9:0]});

        cnt_sum = {1'b0, r_cnt} + (COUNT_BITS + 1)'(nu);
        cnt_mid = cnt_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : cnt_sum[COUNT_BITS-1:0];
        cnt_ext = 32'(cnt_mid);
    end

    // words of this byte in order: units first, then the terminator
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            res[i].code  = '0;
            res[i].term  = 1'b1;
            res[i].total = cnt_ext[TW-1:0];
        end
        if (nu != 2'd0) begin
            res[0].code  = u0;
            res[0].term  = 1'b0;
            res[0].total = '0;
        end
        if (nu == 2'd2) begin
            res[1].code  = u1;
            res[1].term  = 1'b0;
            res[1].total = '0;
        end
        n_res = nu + {1'b0, term_go};
    end

    // output queue: head in entry 0, the held byte moves when all its words fit
    always_comb begin
        pop    = o_m_tvalid && i_m_tready;
        q_base = r_q_cnt - {1'b0, pop};
        q_need = {1'b0, q_base} + {1'b0, n_res};
        move   = r_in_valid && (q_need <= 3'd3);

        n_q     = r_q;
        n_q_cnt = q_base;
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
        end
        if (move) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_res) begin
                    n_q[q_base + 2'(i)] = res[i];
                end
            end
            n_q_cnt = q_need[1:0];
        end
        n_cnt = move ? cnt_mid : r_cnt;
    end

    assign o_s_tready = !r_in_valid || move;
    assign o_m_tvalid = (r_q_cnt != 2'd0);
    assign o_m_tdata  = {5'b0, r_q[0].total, r_q[0].code};
    assign o_m_tlast  = r_q[0].term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide     <= 1'b1;
            r_in_valid <= 1'b0;
            r_acc      <= '0;
            r_rem      <= '0;
            r_len      <= '0;
            r_cnt      <= '0;
            r_ended    <= 1'b0;
            r_q_cnt    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_wide <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (move) begin
                r_acc   <= n_acc;
                r_rem   <= n_rem;
                r_len   <= n_len;
                r_ended <= n_ended;
            end
            r_cnt   <= n_cnt;
            r_q_cnt <= n_q_cnt;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        r_q <= n_q;
    end

endmodule

// ===== rtl/core/u8dec_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8dec_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [u8dec_pkg::TDATA_OUT_W-1:0] o_m_tdata,
    input logic                              o_m_tlast
);

    localparam int CW = u8dec_pkg::CODE_W;
    localparam int TW = u8dec_pkg::TOTAL_W;

    logic [CW-1:0]                   code;
    logic [TW-1:0]                   total;
    logic                            stalled;
    logic [u8dec_pkg::TDATA_OUT_W:0] word;

    assign code    = o_m_tdata[CW-1:0];
    assign total   = o_m_tdata[CW+TW-1:CW];
    assign stalled = o_m_tvalid && !i_m_tready;
    assign word    = {o_m_tlast, o_m_tdata};

    // stalled word holds
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, stalled, o_m_tvalid && $stable(word))
    // only the terminator carries a unit count
    `ASSERT_IMPLIES(a_total_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, total == '0)
    // terminator code is zero
    `ASSERT_IMPLIES(a_term_code, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, code == '0)
    // nothing follows a delivered terminator
    `ASSERT_NEXT(a_term_final, i_clk, i_rst_n, o_m_tvalid && o_m_tlast && i_m_tready, !o_m_tvalid)

endmodule

bind utf8_stream_to_utf16_or_utf32 u8dec_checker u_u8dec_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CODE_W      = u8dec_pkg::CODE_W;
    localparam int TOTAL_W     = u8dec_pkg::TOTAL_W;
    localparam int TDATA_IN_W  = u8dec_pkg::TDATA_IN_W;
    localparam int TDATA_OUT_W = u8dec_pkg::TDATA_OUT_W;
    localparam int COUNT_BITS  = u8dec_pkg::COUNT_BITS_DEF;
    localparam int SETTLE_CYC  = 6;     // margin past the input register and the output queue
    localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
    localparam int PHASE_BYTES = 48;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;

    // shadow decoder state
    logic                  utf32_mode;
    logic [CODE_W-1:0]     code_acc;
    logic [2:0]            cont_left;
    logic [2:0]            seq_len;
    logic [COUNT_BITS-1:0] unit_count;
    logic                  text_closed;

    u8dec_pkg::t_result expected_words[$];
    int      error_count  = 0;
    int      byte_count   = 0;
    int      stall_cycles = 0;
    int      idle_pct     = 0;
    int      stall_pct    = 0;

    utf8_stream_to_utf16_or_utf32 #(
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------- prediction ----------------

    function automatic void push_unit(input logic [CODE_W-1:0] code);
        u8dec_pkg::t_result w;
        w.code  = code;
        w.term  = 1'b0;
        w.total = '0;
        expected_words.push_back(w);
        if (unit_count != {COUNT_BITS{1'b1}})
            unit_count++;
    endfunction

    function automatic void push_code();
        logic [31:0] ofs;
        if (utf32_mode) begin
            push_unit(code_acc);
        end else if (seq_len <= 3) begin
            push_unit(CODE_W'(code_acc[15:0]));
        end else begin
            // offset wraps for overlong values; only the 10-bit halves matter
            ofs = {1'b0, code_acc} - 32'(u8dec_pkg::SUR_OFS);
            push_unit(CODE_W'(u8dec_pkg::SUR_HI | 16'(ofs[19:10])));
            push_unit(CODE_W'(u8dec_pkg::SUR_LO | 16'(ofs[9:0])));
        end
    endfunction

    function automatic void push_end();
        u8dec_pkg::t_result w;
        w.code  = '0;
        w.term  = 1'b1;
        w.total = TOTAL_W'(unit_count);
        expected_words.push_back(w);
        text_closed = 1'b1;
        cont_left   = '0;
        seq_len     = '0;
        code_acc    = '0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic last);
        if (text_closed)
            return;
        if (cont_left != 0) begin
            // any byte here counts as continuation, NUL included
            code_acc = {code_acc[CODE_W-7:0], b[5:0]};
            cont_left--;
            if (cont_left == 0)
                push_code();
        end else if (b == 8'h00) begin
            push_end();
            return;
        end else if (b[7:6] == 2'b10 || b >= 8'hFE) begin
            // stray continuation or impossible lead: dropped
        end else begin
            if (!b[7]) begin
                seq_len = 3'd1; code_acc = CODE_W'(b[6:0]);
            end else if (b[7:5] == 3'b110) begin
                seq_len = 3'd2; code_acc = CODE_W'(b[4:0]);
            end else if (b[7:4] == 4'b1110) begin
                seq_len = 3'd3; code_acc = CODE_W'(b[3:0]);
            end else if (b[7:3] == 5'b11110) begin
                seq_len = 3'd4; code_acc = CODE_W'(b[2:0]);
            end else if (b[7:2] == 6'b111110) begin
                seq_len = 3'd5; code_acc = CODE_W'(b[1:0]);
            end else begin
                seq_len = 3'd6; code_acc = CODE_W'(b[0]);
            end
            cont_left = seq_len - 3'd1;
            if (seq_len == 3'd1)
                push_code();
        end
        if (last)
            push_end();
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h, want %0h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk) begin : check_words
        u8dec_pkg::t_result w;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with none pending", 32'(m_tdata[CODE_W-1:0]), 32'd0);
            end else begin
                w = expected_words.pop_front();
                if (m_tdata[CODE_W-1:0] !== w.code)
                    report_mismatch("code_unit", 32'(m_tdata[CODE_W-1:0]), 32'(w.code));
                if (m_tlast !== w.term)
                    report_mismatch("is_terminator", 32'(m_tlast), 32'(w.term));
                if (m_tdata[CODE_W+TOTAL_W-1:CODE_W] !== w.total)
                    report_mismatch("total_units", 32'(m_tdata[CODE_W+TOTAL_W-1:CODE_W]),
                                    32'(w.total));
            end
        end
    end

    // no handshake on any channel for too long ends the run
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- driving ----------------

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while (gap < 200 && $urandom_range(99) < idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        predict_byte(b, last);
        byte_count++;
    endtask

    // drop valid, let every pending word out, then cover in-flight bytes
    task automatic settle_output();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        settle_output();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        utf32_mode = mode;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random byte that can never land as a NUL lead
    function automatic logic [7:0] filler_byte(input bit loose);
        logic [7:0] b;
        b = loose ? 8'($urandom) : {2'b10, 6'($urandom)};
        if (b == 8'h00 && cont_left == 0)
            b = 8'h80;
        return b;
    endfunction

    task automatic send_sequence();
        int         len;
        int         pick;
        logic [7:0] lead;
        pick = $urandom_range(99);
        len  = (pick < 30) ? 1 : (pick < 50) ? 2 : (pick < 65) ? 3 :
               (pick < 82) ? 4 : (pick < 91) ? 5 : 6;
        case (len)
            1:       lead = 8'($urandom_range(127, 1));
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            4:       lead = {5'b11110, 3'($urandom)};
            5:       lead = {6'b111110, 2'($urandom)};
            default: lead = {7'b1111110, 1'($urandom)};
        endcase
        send_byte(lead, 1'b0);
        for (int i = 1; i < len; i++)
            send_byte(filler_byte($urandom_range(9) == 0), 1'b0);
    endtask

    task automatic send_noise();
        case ($urandom_range(2))
            0:       send_byte({2'b10, 6'($urandom)}, 1'b0);
            1:       send_byte({7'h7F, 1'($urandom)}, 1'b0);
            default: send_byte(filler_byte(1'b1), 1'b0);
        endcase
    endtask

    task automatic run_phase(input int idle, input int stall, input logic mode,
                             input bit mid_pause);
        int  start;
        bit  paused;
        write_mode(mode);
        idle_pct  = idle;
        stall_pct = stall;
        start     = byte_count;
        paused    = 0;
        while (byte_count - start < PHASE_BYTES) begin
            if (mid_pause && !paused && byte_count - start >= PHASE_BYTES / 2) begin
                settle_output();
                paused = 1;
            end
            if ($urandom_range(99) < 80)
                send_sequence();
            else
                send_noise();
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_utf32_directed();
        write_mode(1'b1);
        idle_pct  = 0;
        stall_pct = 0;
        send_byte(8'h7F, 1'b0);                      // top of ASCII
        send_byte(8'h80, 1'b0);                      // stray continuations
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFE, 1'b0);                      // impossible leads
        send_byte(8'hFF, 1'b0);
        send_byte(8'hDF, 1'b0);                      // 2-byte max
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC2, 1'b0);                      // NUL inside a sequence
        send_byte(8'h00, 1'b0);
        send_byte(8'hFD, 1'b0);                      // 6-byte, all 31 bits set
        repeat (5) send_byte(8'hBF, 1'b0);
        send_byte(8'hE2, 1'b0);                      // left open over the mode write
    endtask

    task automatic test_utf16_directed();
        write_mode(1'b0);
        idle_pct  = 12;
        stall_pct = 12;
        send_byte(8'h82, 1'b0);                      // finishes in UTF-16 mode
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF4, 1'b0);                      // U+10FFFF as a pair
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF0, 1'b0);                      // overlong zero, offset wraps
        repeat (3) send_byte(8'h80, 1'b0);
    endtask

    task automatic test_random_traffic();
        run_phase(0,  0,  1'b0, 0);
        run_phase(81, 0,  1'b1, 0);
        run_phase(0,  81, 1'b0, 0);
        run_phase(12, 12, 1'($urandom), 1);
    endtask

    // only one string per reset, so the closing case is picked at random
    task automatic test_end_of_text();
        write_mode(1'($urandom));
        while (cont_left != 0)
            send_byte({2'b10, 6'($urandom)}, 1'b0);
        case ($urandom_range(2))
            0: begin                                 // NUL lead closes
                send_byte(8'h41, 1'b0);
                send_byte(8'h00, 1'($urandom));
            end
            1: begin                                 // sequence completes on the last byte
                send_byte(8'hF0, 1'b0);
                send_byte(8'h9F, 1'b0);
                send_byte(8'h98, 1'b0);
                send_byte(8'h80, 1'b1);
            end
            default: begin                           // cut short by tlast
                send_byte(8'hE2, 1'b0);
                send_byte(8'h82, 1'b1);
            end
        endcase
    endtask

    task automatic test_after_end();
        repeat (8) send_byte(8'($urandom), 1'($urandom));
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        utf32_mode  = 1'b1;
        code_acc    = '0;
        cont_left   = '0;
        seq_len     = '0;
        unit_count  = '0;
        text_closed = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_utf32_directed();
        test_utf16_directed();
        test_random_traffic();
        test_end_of_text();
        test_after_end();
        settle_output();

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/u8dec_pkg.sv
rtl/core/utf8_stream_to_utf16_or_utf32.sv
rtl/core/u8dec_checker.sv
bench/tb.sv
